### rtl/idq_pkg.sv
// Shared types and codes for the indexed deque block.
// Used by the controller, the datapath and the top level; depends on nothing.
package idq_pkg;

    // Operation codes carried by a request.
    localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [2:0] OP_POP_BACK   = 3'd1;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd2;
    localparam logic [2:0] OP_POP_FRONT  = 3'd3;
    localparam logic [2:0] OP_INSERT     = 3'd4;
    localparam logic [2:0] OP_READ       = 3'd5;
    localparam logic [2:0] OP_FIND       = 3'd6;

    // Sticky error codes.
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_EMPTY     = 3'd1;
    localparam logic [2:0] ERR_INDEX     = 3'd2;
    localparam logic [2:0] ERR_NOT_FOUND = 3'd3;
    localparam logic [2:0] ERR_FULL      = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FETCH,
        S_TAKE,
        S_UP_RD,
        S_UP_WR,
        S_DN_RD,
        S_DN_WR,
        S_FIND_RD,
        S_FIND_CMP,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_COUNT,
        PTR_CNT_M1,
        PTR_IDX,
        PTR_INC,
        PTR_DEC
    } ptr_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef enum logic [1:0] {
        RA_PTR,
        RA_PTR_M1,
        RA_PTR_P1
    } rd_addr_t;

    typedef enum logic {
        WA_PTR,
        WA_COUNT
    } wr_addr_t;

    typedef enum logic {
        WD_VALUE,
        WD_RAM
    } wr_data_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_ONES,
        RES_RAM,
        RES_PTR
    } res_sel_t;

    typedef struct packed {
        logic       load;
        ptr_op_t    ptr_op;
        cnt_op_t    cnt_op;
        logic       rd_en;
        rd_addr_t   rd_addr;
        logic       wr_en;
        wr_addr_t   wr_addr;
        wr_data_t   wr_data;
        logic       res_we;
        res_sel_t   res_sel;
        logic       err_we;
        logic [2:0] err_code;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       full;
        logic       empty;
        logic       rd_ok;
        logic       ins_ok;
        logic       at_pos;
        logic       at_count;
        logic       at_last;
        logic       match;
    } dp_status_t;

endpackage

### rtl/idq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; no package needed.
module idq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/idq_dpath.sv
// Datapath of the indexed deque: request registers, pointer, count, error,
// result register and the element RAM. Depends on idq_pkg and idq_ram.
module idq_dpath #(
    parameter int DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  idq_pkg::dp_cmd_t    cmd,
    input  logic [2:0]          operation,
    input  logic signed [31:0]  value,
    input  logic signed [5:0]   index,
    output idq_pkg::dp_status_t st,
    output logic signed [31:0]  data,
    output logic [2:0]          error,
    output logic [4:0]          count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [2:0]         op_reg;
    logic signed [31:0] value_reg;
    logic signed [5:0]  index_reg;
    logic [CW-1:0]      ptr_reg, ptr_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [2:0]         err_reg, err_next;
    logic [31:0]        res_reg, res_next;

    logic [CW-1:0] ptr_m1, ptr_p1, pos, idx_cw;
    logic [31:0]   idx_ext, cnt_ext, ptr_ext;
    logic [AW-1:0] ram_rd_addr, ram_wr_addr;
    logic [31:0]   ram_wr_data, ram_rd_data;

    assign idx_ext = 32'(index_reg[4:0]);
    assign cnt_ext = 32'(count_reg);
    assign ptr_ext = 32'(ptr_reg);
    assign idx_cw  = CW'(idx_ext);
    assign ptr_m1  = ptr_reg - CW'(1);
    assign ptr_p1  = ptr_reg + CW'(1);

    // An insert after index -1 lands at the front.
    assign pos = (op_reg == idq_pkg::OP_PUSH_FRONT || index_reg == -6'sd1) ?
                 '0 : CW'(idx_ext + 32'd1);

    always_comb
    begin
        st.op       = op_reg;
        st.full     = (cnt_ext >= 32'(DEPTH));
        st.empty    = (count_reg == '0);
        st.rd_ok    = !index_reg[5] && (idx_ext < cnt_ext);
        st.ins_ok   = (index_reg == -6'sd1) || (!index_reg[5] && (idx_ext < cnt_ext));
        st.at_pos   = (ptr_reg == pos);
        st.at_count = (ptr_reg == count_reg);
        st.at_last  = ((ptr_ext + 32'd1) >= cnt_ext);
        st.match    = (ram_rd_data == value_reg);
    end

    always_comb
    begin
        case (cmd.rd_addr)
            idq_pkg::RA_PTR_M1: ram_rd_addr = ptr_m1[AW-1:0];
            idq_pkg::RA_PTR_P1: ram_rd_addr = ptr_p1[AW-1:0];
            default:            ram_rd_addr = ptr_reg[AW-1:0];
        endcase
        ram_wr_addr = (cmd.wr_addr == idq_pkg::WA_COUNT) ? count_reg[AW-1:0] :
                                                           ptr_reg[AW-1:0];
        ram_wr_data = (cmd.wr_data == idq_pkg::WD_RAM) ? ram_rd_data : value_reg;
    end

    always_comb
    begin
        case (cmd.ptr_op)
            idq_pkg::PTR_ZERO:   ptr_next = '0;
            idq_pkg::PTR_COUNT:  ptr_next = count_reg;
            idq_pkg::PTR_CNT_M1: ptr_next = count_reg - CW'(1);
            idq_pkg::PTR_IDX:    ptr_next = idx_cw;
            idq_pkg::PTR_INC:    ptr_next = ptr_p1;
            idq_pkg::PTR_DEC:    ptr_next = ptr_m1;
            default:             ptr_next = ptr_reg;
        endcase

        case (cmd.cnt_op)
            idq_pkg::CNT_INC: count_next = count_reg + CW'(1);
            idq_pkg::CNT_DEC: count_next = count_reg - CW'(1);
            default:          count_next = count_reg;
        endcase

        err_next = cmd.err_we ? cmd.err_code : err_reg;

        res_next = res_reg;
        if (cmd.res_we)
        begin
            case (cmd.res_sel)
                idq_pkg::RES_ONES: res_next = '1;
                idq_pkg::RES_RAM:  res_next = ram_rd_data;
                idq_pkg::RES_PTR:  res_next = ptr_ext;
                default:           res_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            err_reg   <= idq_pkg::ERR_NONE;
        end
        else
        begin
            count_reg <= count_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= operation;
            value_reg <= value;
            index_reg <= index;
        end
        ptr_reg <= ptr_next;
        res_reg <= res_next;
    end

    idq_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign data  = res_reg;
    assign error = err_reg;
    assign count = cnt_ext[4:0];

endmodule

### rtl/idq_ctrl.sv
// Controller of the indexed deque: sequences each request through decode,
// element shifts and searches. Depends on idq_pkg.
module idq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  idq_pkg::dp_status_t st,
    output idq_pkg::dp_cmd_t    cmd,
    output logic                busy,
    output logic                done
);

    idq_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= idq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.ptr_op   = idq_pkg::PTR_HOLD;
        cmd.cnt_op   = idq_pkg::CNT_HOLD;
        cmd.rd_addr  = idq_pkg::RA_PTR;
        cmd.wr_addr  = idq_pkg::WA_PTR;
        cmd.wr_data  = idq_pkg::WD_VALUE;
        cmd.res_sel  = idq_pkg::RES_ZERO;
        cmd.err_code = idq_pkg::ERR_NONE;
        busy         = (state_reg != idq_pkg::S_IDLE);
        done         = (state_reg == idq_pkg::S_DONE);

        unique case (state_reg)
            idq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = idq_pkg::S_DECODE;
                end
            end

            idq_pkg::S_DECODE:
            begin
                unique case (st.op) inside
                    idq_pkg::OP_PUSH_BACK:
                    begin
                        cmd.res_we = 1'b1;
                        cmd.err_we = 1'b1;
                        state_next = idq_pkg::S_DONE;
                        if (st.full)
                        begin
                            cmd.err_code = idq_pkg::ERR_FULL;
                        end
                        else
                        begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_addr = idq_pkg::WA_COUNT;
                            cmd.cnt_op  = idq_pkg::CNT_INC;
                        end
                    end

                    idq_pkg::OP_PUSH_FRONT, idq_pkg::OP_INSERT:
                    begin
                        cmd.res_we = 1'b1;
                        if (st.op == idq_pkg::OP_INSERT && !st.ins_ok)
                        begin
                            cmd.err_we   = 1'b1;
                            cmd.err_code = idq_pkg::ERR_INDEX;
                            state_next   = idq_pkg::S_DONE;
                        end
                        else if (st.full)
                        begin
                            cmd.err_we   = 1'b1;
                            cmd.err_code = idq_pkg::ERR_FULL;
                            state_next   = idq_pkg::S_DONE;
                        end
                        else
                        begin
                            cmd.ptr_op = idq_pkg::PTR_COUNT;
                            state_next = idq_pkg::S_UP_RD;
                        end
                    end

                    idq_pkg::OP_POP_BACK, idq_pkg::OP_POP_FRONT:
                    begin
                        if (st.empty)
                        begin
                            cmd.res_we   = 1'b1;
                            cmd.res_sel  = idq_pkg::RES_ONES;
                            cmd.err_we   = 1'b1;
                            cmd.err_code = idq_pkg::ERR_EMPTY;
                            state_next   = idq_pkg::S_DONE;
                        end
                        else if (st.op == idq_pkg::OP_POP_BACK)
                        begin
                            cmd.ptr_op = idq_pkg::PTR_CNT_M1;
                            cmd.cnt_op = idq_pkg::CNT_DEC;
                            state_next = idq_pkg::S_FETCH;
                        end
                        else
                        begin
                            cmd.ptr_op = idq_pkg::PTR_ZERO;
                            state_next = idq_pkg::S_FETCH;
                        end
                    end

                    idq_pkg::OP_READ:
                    begin
                        if (!st.rd_ok)
                        begin
                            cmd.res_we   = 1'b1;
                            cmd.res_sel  = idq_pkg::RES_ONES;
                            cmd.err_we   = 1'b1;
                            cmd.err_code = idq_pkg::ERR_INDEX;
                            state_next   = idq_pkg::S_DONE;
                        end
                        else
                        begin
                            cmd.ptr_op = idq_pkg::PTR_IDX;
                            state_next = idq_pkg::S_FETCH;
                        end
                    end

                    idq_pkg::OP_FIND:
                    begin
                        cmd.ptr_op = idq_pkg::PTR_ZERO;
                        state_next = idq_pkg::S_FIND_RD;
                    end

                    default:
                    begin
                        cmd.res_we = 1'b1;
                        state_next = idq_pkg::S_DONE;
                    end
                endcase
            end

            idq_pkg::S_FETCH:
            begin
                cmd.rd_en  = 1'b1;
                state_next = idq_pkg::S_TAKE;
            end

            idq_pkg::S_TAKE:
            begin
                cmd.res_we  = 1'b1;
                cmd.res_sel = idq_pkg::RES_RAM;
                // A successful read leaves the sticky error as it was.
                if (st.op == idq_pkg::OP_READ)
                begin
                    state_next = idq_pkg::S_DONE;
                end
                else
                begin
                    cmd.err_we = 1'b1;
                    state_next = (st.op == idq_pkg::OP_POP_FRONT) ? idq_pkg::S_DN_RD :
                                                                     idq_pkg::S_DONE;
                end
            end

            // Pop front: move each element one place toward the front.
            idq_pkg::S_DN_RD:
            begin
                if (st.at_last)
                begin
                    cmd.cnt_op = idq_pkg::CNT_DEC;
                    state_next = idq_pkg::S_DONE;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = idq_pkg::RA_PTR_P1;
                    state_next  = idq_pkg::S_DN_WR;
                end
            end

            idq_pkg::S_DN_WR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_data = idq_pkg::WD_RAM;
                cmd.ptr_op  = idq_pkg::PTR_INC;
                state_next  = idq_pkg::S_DN_RD;
            end

            // Push front and insert: open a gap by moving the tail back.
            idq_pkg::S_UP_RD:
            begin
                if (st.at_pos)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.cnt_op = idq_pkg::CNT_INC;
                    cmd.err_we = 1'b1;
                    state_next = idq_pkg::S_DONE;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = idq_pkg::RA_PTR_M1;
                    state_next  = idq_pkg::S_UP_WR;
                end
            end

            idq_pkg::S_UP_WR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_data = idq_pkg::WD_RAM;
                cmd.ptr_op  = idq_pkg::PTR_DEC;
                state_next  = idq_pkg::S_UP_RD;
            end

            idq_pkg::S_FIND_RD:
            begin
                if (st.at_count)
                begin
                    cmd.res_we   = 1'b1;
                    cmd.res_sel  = idq_pkg::RES_ONES;
                    cmd.err_we   = 1'b1;
                    cmd.err_code = idq_pkg::ERR_NOT_FOUND;
                    state_next   = idq_pkg::S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = idq_pkg::S_FIND_CMP;
                end
            end

            idq_pkg::S_FIND_CMP:
            begin
                if (st.match)
                begin
                    cmd.res_we  = 1'b1;
                    cmd.res_sel = idq_pkg::RES_PTR;
                    cmd.err_we  = 1'b1;
                    state_next  = idq_pkg::S_DONE;
                end
                else
                begin
                    cmd.ptr_op = idq_pkg::PTR_INC;
                    state_next = idq_pkg::S_FIND_RD;
                end
            end

            idq_pkg::S_DONE:
            begin
                state_next = idq_pkg::S_IDLE;
            end

            default:
            begin
                state_next = idq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### rtl/indexed_deque_insert_find_top.sv
// Indexed deque, one request at a time. Push front and insert open a gap and pop front closes
// one, moving each element with one RAM read and one write; find reads the elements in order
// until a hit or the end of the list. busy stays high through done, so a new request is taken
// only after the last one is done. Reset clears count and error; element contents are
// undefined until written. No stalls.
module indexed_deque_insert_find_top #(
    parameter int DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         operation,
    input  logic signed [31:0] value,
    input  logic signed [5:0]  index,
    output logic               done,
    output logic signed [31:0] data,
    output logic [2:0]         error,
    output logic [4:0]         count
);

    idq_pkg::dp_cmd_t    cmd;
    idq_pkg::dp_status_t st;

    idq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    idq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .operation (operation),
        .value     (value),
        .index     (index),
        .st        (st),
        .data      (data),
        .error     (error),
        .count     (count)
    );

endmodule

### tb/idq_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the indexed deque: keeps a shadow copy of the stored list,
// predicts the result of every accepted request and compares each done strobe.
// Depends on idq_pkg for the operation and error codes.
module idq_result_checker
    import idq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [2:0]         operation,
    input  logic signed [31:0] value,
    input  logic signed [5:0]  index,
    input  logic               done,
    input  logic signed [31:0] data,
    input  logic [2:0]         error,
    input  logic [4:0]         count,
    output int                 failures,
    output int                 pending
);

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] data;
        logic [2:0]         error;
        logic [4:0]         count;
    } deque_result_t;

    logic signed [31:0] shadow_words[$];
    logic [2:0]         shadow_error;
    deque_result_t      pending_results[$];
    deque_result_t      oldest;
    deque_result_t      predicted;

    task automatic report_mismatch(input string what);
        failures++;
        if (failures <= 40)
            $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // Applies one request to the shadow list and returns the result it should give.
    function automatic deque_result_t apply_deque_op(input logic [2:0] op,
                                                     input logic signed [31:0] word,
                                                     input logic signed [5:0] pos_field);
        deque_result_t r;
        int pos;
        int held;
        int k;
        bit is_full;
        bit found;
        pos = pos_field;
        held = shadow_words.size();
        is_full = held >= DEPTH;
        found = 1'b0;
        r.op = op;
        r.data = '0;
        case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT:
            begin
                if (is_full)
                    shadow_error = ERR_FULL;
                else
                begin
                    if (op == OP_PUSH_BACK)
                        shadow_words.insert(held, word);
                    else
                        shadow_words.insert(0, word);
                    shadow_error = ERR_NONE;
                end
            end
            OP_POP_BACK, OP_POP_FRONT:
            begin
                if (held == 0)
                begin
                    shadow_error = ERR_EMPTY;
                    r.data = '1;
                end
                else
                begin
                    if (op == OP_POP_BACK)
                    begin
                        r.data = shadow_words[held - 1];
                        shadow_words.delete(held - 1);
                    end
                    else
                    begin
                        r.data = shadow_words[0];
                        shadow_words.delete(0);
                    end
                    shadow_error = ERR_NONE;
                end
            end
            OP_INSERT:
            begin
                // The index check wins over the full check.
                if (pos < -1 || pos >= held)
                    shadow_error = ERR_INDEX;
                else if (is_full)
                    shadow_error = ERR_FULL;
                else
                begin
                    shadow_words.insert(pos + 1, word);
                    shadow_error = ERR_NONE;
                end
            end
            OP_READ:
            begin
                // A good read leaves the sticky error as it was.
                if (pos < 0 || pos >= held)
                begin
                    shadow_error = ERR_INDEX;
                    r.data = '1;
                end
                else
                    r.data = shadow_words[pos];
            end
            OP_FIND:
            begin
                r.data = '1;
                shadow_error = ERR_NOT_FOUND;
                for (k = 0; k < held && !found; k++)
                begin
                    if (shadow_words[k] == word)
                    begin
                        r.data = k;
                        shadow_error = ERR_NONE;
                        found = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.error = shadow_error;
        r.count = 5'(shadow_words.size());
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_words.delete();
            shadow_error = ERR_NONE;
            pending_results.delete();
            failures = 0;
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("result with no request waiting: data %0d", data));
                else
                begin
                    oldest = pending_results[0];
                    pending_results.delete(0);
                    if (data !== oldest.data)
                        report_mismatch($sformatf("op %0d data %0d, predicted %0d",
                                                  oldest.op, data, oldest.data));
                    if (error !== oldest.error)
                        report_mismatch($sformatf("op %0d error %0d, predicted %0d",
                                                  oldest.op, error, oldest.error));
                    if (count !== oldest.count)
                        report_mismatch($sformatf("op %0d count %0d, predicted %0d",
                                                  oldest.op, count, oldest.count));
                end
            end
            if (start && !busy)
            begin
                predicted = apply_deque_op(operation, value, index);
                pending_results.insert(pending_results.size(), predicted);
            end
            pending <= pending_results.size();
        end
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Top of the indexed deque testbench: clock, reset and request stimulus.
// Depends on idq_pkg, indexed_deque_insert_find_top and idq_result_checker.
module tb;
    import idq_pkg::*;

    localparam int DEPTH = 16;
    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int RANDOM_REQUESTS = 1750;
    localparam int PHASE_LENGTH = 250;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT = 400000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [2:0]         operation = OP_PUSH_BACK;
    logic signed [31:0] value = '0;
    logic signed [5:0]  index = '0;
    logic               busy;
    logic               done;
    logic signed [31:0] data;
    logic [2:0]         error;
    logic [4:0]         count;

    int                 failures;
    int                 pending;
    int                 cycle_count = 0;
    int                 idle_pct = 0;
    logic signed [31:0] word_pool[8];

    always #1 clk = ~clk;

    indexed_deque_insert_find_top #(
        .DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .operation(operation),
        .value(value),
        .index(index),
        .done(done),
        .data(data),
        .error(error),
        .count(count)
    );

    idq_result_checker #(
        .DEPTH(DEPTH)
    ) result_check (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .operation(operation),
        .value(value),
        .index(index),
        .done(done),
        .data(data),
        .error(error),
        .count(count),
        .failures(failures),
        .pending(pending)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Holds start high until the block takes the request; start only drops
    // while the sender idles, so it never gets two assignments in one step.
    task automatic send_request(input logic [2:0] op, input logic signed [31:0] word,
                                input logic signed [5:0] pos);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        operation <= op;
        value <= word;
        index <= pos;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Words come mostly from a small pool so that finds often hit.
    function automatic logic signed [31:0] pick_word();
        if ($urandom_range(0, 9) < 6)
            return word_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    function automatic logic signed [5:0] pick_position();
        if ($urandom_range(0, 4) != 0)
            return 6'(int'($urandom_range(0, DEPTH + 1)) - 1);
        return 6'($urandom);
    endfunction

    // While growing, pushes dominate so the list keeps reaching full;
    // while shrinking, pops dominate so it keeps reaching empty.
    function automatic logic [2:0] pick_operation(input bit growing);
        int roll;
        roll = $urandom_range(0, 99);
        if (growing)
        begin
            if (roll < 30) return OP_PUSH_BACK;
            if (roll < 50) return OP_PUSH_FRONT;
            if (roll < 70) return OP_INSERT;
            if (roll < 76) return OP_POP_BACK;
            if (roll < 82) return OP_POP_FRONT;
            if (roll < 90) return OP_READ;
            if (roll < 98) return OP_FIND;
            return OP_UNUSED;
        end
        if (roll < 8)  return OP_PUSH_BACK;
        if (roll < 14) return OP_PUSH_FRONT;
        if (roll < 20) return OP_INSERT;
        if (roll < 45) return OP_POP_BACK;
        if (roll < 70) return OP_POP_FRONT;
        if (roll < 82) return OP_READ;
        if (roll < 96) return OP_FIND;
        return OP_UNUSED;
    endfunction

    initial
    begin
        int  n;
        int  tide_left;
        bit  growing;
        word_pool = '{32'sd0, -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd1,
                      $urandom, $urandom, $urandom};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list: both pops, a read and a find fail; insert after 0 is out of range.
        send_request(OP_POP_BACK, 32'sd0, 6'sd0);
        send_request(OP_POP_FRONT, 32'sd0, 6'sd0);
        send_request(OP_READ, 32'sd0, 6'sd0);
        send_request(OP_FIND, 32'sd0, 6'sd0);
        send_request(OP_INSERT, 32'sd5, 6'sd0);
        send_request(OP_INSERT, 32'sh8000_0000, -6'sd1);
        send_request(OP_PUSH_BACK, 32'sh7FFF_FFFF, 6'sd0);
        send_request(OP_PUSH_FRONT, -32'sd1, 6'sd0);
        send_request(OP_INSERT, 32'sd0, 6'sd2);
        send_request(OP_INSERT, 32'sh1234_5678, 6'sd1);
        send_request(OP_INSERT, 32'sd9, -6'sd32);
        // A good read right after an index error must keep that error.
        send_request(OP_READ, 32'sd0, 6'sd4);
        send_request(OP_READ, 32'sd0, -6'sd1);
        send_request(OP_READ, 32'sd0, 6'sd31);
        send_request(OP_FIND, 32'sh7FFF_FFFF, 6'sd0);
        send_request(OP_FIND, 32'sh5555_AAAA, 6'sd0);
        send_request(OP_UNUSED, -32'sd1, 6'sd31);
        send_request(OP_POP_FRONT, 32'sd0, 6'sd0);
        send_request(OP_POP_BACK, 32'sd0, 6'sd0);

        // The first tide grows long enough to fill the list.
        growing = 1'b1;
        tide_left = $urandom_range(40, 70);
        for (n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % PHASE_LENGTH == 0)
            begin
                case ((n / PHASE_LENGTH) % 3)
                    0: idle_pct = 0;
                    1: idle_pct = 70;
                    default: idle_pct = 20;
                endcase
            end
            if (tide_left == 0)
            begin
                growing = !growing;
                tide_left = $urandom_range(20, 60);
            end
            tide_left--;
            send_request(pick_operation(growing), pick_word(), pick_position());
        end
        start <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
